FILE: hdl/cat_pkg.sv
// ----------------------------------------------------------------------------
// cat_pkg: shared types and constants of the cubic axis trajectory core
// Item structs, function codes and the fixed arithmetic widths.
// ----------------------------------------------------------------------------
package cat_pkg;

    // position format, signed Q16.16
    localparam int POS_BITS     = 32;
    // fraction bits of the normalized time s
    localparam int S_FRAC       = 16;
    // s and the blend factor h run 0..1.0, one integer bit
    localparam int S_BITS       = S_FRAC + 1;
    localparam int H_BITS       = S_FRAC + 1;
    localparam int PERIOD_BITS  = 16;
    localparam int TICK_BITS    = 32;
    localparam int AXIS_ID_BITS = 3;
    localparam int AXES_DEF     = 6;

    // shared multiplier operands: a takes s, s^2 or an endpoint difference magnitude
    localparam int MUL_A_BITS   = (2 * S_FRAC + 1 > POS_BITS + 1) ?
                                  (2 * S_FRAC + 1) : (POS_BITS + 1);
    localparam int MUL_B_BITS   = S_BITS;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

    // function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_EVAL  = 2'd2;

    typedef struct packed {
        logic [1:0]                    func;
        logic [AXIS_ID_BITS-1:0]       axis_index;
        logic signed [POS_BITS-1:0]    start_position;
        logic signed [POS_BITS-1:0]    end_position;
        logic [PERIOD_BITS-1:0]        move_period_ms;
        logic [TICK_BITS-1:0]          tick_now;
    } t_in_item;

    typedef struct packed {
        logic [AXIS_ID_BITS-1:0]       out_axis;
        logic signed [POS_BITS-1:0]    position;
        logic                          timed_out;
        logic                          last;
    } t_out_item;

    // divider status toward the sequencer
    typedef struct packed {
        logic                          done;
        logic [S_FRAC-1:0]             quo;
    } t_div_stat;

endpackage

FILE: hdl/cat_divider.sv
// ----------------------------------------------------------------------------
// cat_divider: radix-2 restoring divider for the normalized time
// Computes (dividend << S_FRAC) / divisor, one quotient bit per cycle.
// The dividend must be below the divisor, so the quotient is a pure fraction.
// ----------------------------------------------------------------------------
module cat_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [cat_pkg::PERIOD_BITS-1:0]  i_dividend,
    input  logic [cat_pkg::PERIOD_BITS-1:0]  i_divisor,
    output cat_pkg::t_div_stat               o_stat
);

    localparam int QW = cat_pkg::S_FRAC;
    localparam int RW = cat_pkg::PERIOD_BITS + 1;
    localparam int CW = $clog2(QW);

    logic [RW-1:0]                    r_rem;
    logic [cat_pkg::PERIOD_BITS-1:0]  r_div;
    logic [QW-1:0]                    r_quo;
    logic [CW-1:0]                    r_cnt;
    logic                             r_busy;
    logic                             r_done;

    logic [RW-1:0]                    w_rem2;
    logic                             w_ge;

    // shift in a zero bit and trial subtract
    assign w_rem2 = {r_rem[RW-2:0], 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_div}) : w_rem2;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;

endmodule

FILE: hdl/cat_mult.sv
// ----------------------------------------------------------------------------
// cat_mult: shared unsigned multiplier with registered product
// Used in turn for s^2, s^3 and each axis's difference times h.
// ----------------------------------------------------------------------------
module cat_mult (
    input  logic                            i_clk,
    input  logic [cat_pkg::MUL_A_BITS-1:0]  i_a,
    input  logic [cat_pkg::MUL_B_BITS-1:0]  i_b,
    output logic [cat_pkg::MUL_P_BITS-1:0]  o_p
);

    logic [cat_pkg::MUL_P_BITS-1:0] r_p;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_p <= cat_pkg::MUL_P_BITS'(i_a) * cat_pkg::MUL_P_BITS'(i_b);
    end

    assign o_p = r_p;

endmodule

FILE: hdl/cat_endpoints.sv
// ----------------------------------------------------------------------------
// cat_endpoints: per-axis start and end position store
// One write port for load items, one read port for the axis sequencer.
// ----------------------------------------------------------------------------
module cat_endpoints #(
    parameter int AXES   = cat_pkg::AXES_DEF,
    parameter int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [AXIS_W-1:0]                     i_waddr,
    input  logic signed [cat_pkg::POS_BITS-1:0]   i_wstart,
    input  logic signed [cat_pkg::POS_BITS-1:0]   i_wend,
    input  logic [AXIS_W-1:0]                     i_raddr,
    output logic signed [cat_pkg::POS_BITS-1:0]   o_rstart,
    output logic signed [cat_pkg::POS_BITS-1:0]   o_rend
);

    logic signed [cat_pkg::POS_BITS-1:0] r_start [AXES];
    logic signed [cat_pkg::POS_BITS-1:0] r_end   [AXES];

    // endpoint registers, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
            end
        end else if (i_we) begin
            r_start[i_waddr] <= i_wstart;
            r_end[i_waddr]   <= i_wend;
        end
    end

    assign o_rstart = r_start[i_raddr];
    assign o_rend   = r_end[i_raddr];

endmodule

FILE: hdl/cubic_axis_trajectory_core.sv
// Load and begin items leave the sequencer idle, so the block stays ready for more.
// Evaluate item: the radix-2 divider forms s unless the move has timed out, the
// shared multiplier forms s^2, s^3 and h, and then each axis takes a difference,
// a multiply and an output step that waits while the output register is full.
// The block accepts no new item until the last axis result has been loaded.
// Synchronous active-low reset clears endpoints, start tick and period to zero.
// ----------------------------------------------------------------------------
// cubic_axis_trajectory_core: multi-axis cubic point-to-point trajectory
// Evaluates start + (end - start) * (3s^2 - 2s^3) per axis with one shared
// multiplier and an iterative divider under a one-hot sequencer.
// ----------------------------------------------------------------------------
module cubic_axis_trajectory_core #(
    parameter int AXES = cat_pkg::AXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cat_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cat_pkg::t_out_item  o_out
);

    localparam int AXIS_W = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int AX_ID  = cat_pkg::AXIS_ID_BITS;
    localparam int PB     = cat_pkg::POS_BITS;
    localparam int SF     = cat_pkg::S_FRAC;
    localparam int SB     = cat_pkg::S_BITS;
    localparam int HB     = cat_pkg::H_BITS;
    localparam int AW     = cat_pkg::MUL_A_BITS;
    localparam int PW     = cat_pkg::MUL_P_BITS;
    localparam int TB     = cat_pkg::TICK_BITS;
    localparam int PDB    = cat_pkg::PERIOD_BITS;
    localparam int SQW    = 2 * SF + 1;
    localparam int HFW    = 3 * SF + 3;
    localparam int SUMW   = PB + 4;
    localparam logic [SB-1:0] S_ONE = SB'(1) << SF;
    localparam logic [HB-1:0] H_ONE = HB'(1) << SF;
    localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV   = 8'b0000_0010,
        ST_SQ    = 8'b0000_0100,
        ST_CUBE  = 8'b0000_1000,
        ST_BLEND = 8'b0001_0000,
        ST_DIFF  = 8'b0010_0000,
        ST_MUL   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [AXIS_W-1:0]        r_axis, n_axis;
    logic [TB-1:0]            r_tick;
    logic [PDB-1:0]           r_period;
    logic                     r_tmo;
    logic [SB-1:0]            r_s;
    logic [SQW-1:0]           r_s2;
    logic [HB-1:0]            r_h;
    logic signed [PB-1:0]     r_st;
    logic [PB:0]              r_mag;
    logic                     r_neg;
    logic                     r_out_valid;
    cat_pkg::t_out_item       r_out;

    logic                     w_accept;
    logic                     w_eval;
    logic [TB-1:0]            w_elapsed;
    logic                     w_tmo;
    cat_pkg::t_div_stat       w_div;
    logic [AW-1:0]            w_mul_a;
    logic [SB-1:0]            w_mul_b;
    logic [PW-1:0]            w_prod;
    logic [HFW-1:0]           w_hfull;
    logic signed [PB-1:0]     w_rstart;
    logic signed [PB-1:0]     w_rend;
    logic signed [PW:0]       w_sprod;
    logic signed [PW:0]       w_sshift;
    logic signed [SUMW-1:0]   w_sum;
    logic signed [PB-1:0]     w_pos;
    logic                     w_out_load;
    logic                     w_last;

    // input handshake and item decode
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_eval     = w_accept && (i_in.func == cat_pkg::FUNC_EVAL);
    assign w_elapsed  = i_in.tick_now - r_tick;
    assign w_tmo      = (r_period == '0) || (w_elapsed >= TB'(r_period));

    // move start tick and period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_period <= '0;
        end else if (w_accept && (i_in.func == cat_pkg::FUNC_BEGIN)) begin
            r_tick   <= i_in.tick_now;
            r_period <= i_in.move_period_ms;
        end
    end

    // endpoint store
    cat_endpoints #(
        .AXES   (AXES),
        .AXIS_W (AXIS_W)
    ) u_endpoints (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_accept && (i_in.func == cat_pkg::FUNC_LOAD)
                   && (int'(i_in.axis_index) < AXES)),
        .i_waddr  (AXIS_W'(i_in.axis_index)),
        .i_wstart (i_in.start_position),
        .i_wend   (i_in.end_position),
        .i_raddr  (r_axis),
        .o_rstart (w_rstart),
        .o_rend   (w_rend)
    );

    // normalized time divider, elapsed is below the period here
    cat_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_eval && !w_tmo),
        .i_dividend (w_elapsed[PDB-1:0]),
        .i_divisor  (r_period),
        .o_stat     (w_div)
    );

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            ST_SQ: begin
                w_mul_a = AW'(r_s);
                w_mul_b = r_s;
            end
            ST_CUBE: begin
                w_mul_a = AW'(w_prod[SQW-1:0]);
                w_mul_b = r_s;
            end
            default: begin
                w_mul_a = AW'(r_mag);
                w_mul_b = r_h;
            end
        endcase
    end

    cat_mult u_mult (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // blend factor h = (3 s^2 2^16 - 2 s^3) >> 32
    assign w_hfull = ((HFW'(r_s2) * HFW'(3)) << SF) - (HFW'(w_prod) << 1);

    // offset rounded toward minus infinity, then saturated sum
    assign w_sprod  = r_neg ? -$signed({1'b0, w_prod}) : $signed({1'b0, w_prod});
    assign w_sshift = w_sprod >>> SF;
    assign w_sum    = $signed({{(SUMW-PB){r_st[PB-1]}}, r_st})
                    + $signed(w_sshift[SUMW-1:0]);
    always_comb begin
        priority if (w_sum > SAT_HI) begin
            w_pos = SAT_HI[PB-1:0];
        end else if (w_sum < SAT_LO) begin
            w_pos = SAT_LO[PB-1:0];
        end else begin
            w_pos = w_sum[PB-1:0];
        end
    end

    assign w_last     = (r_axis == AXIS_W'(AXES - 1));
    assign w_out_load = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                if (w_eval) begin
                    n_state = w_tmo ? ST_SQ : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                n_state = ST_CUBE;
            end
            ST_CUBE: begin
                n_state = ST_BLEND;
            end
            ST_BLEND: begin
                n_state = ST_DIFF;
                n_axis  = '0;
            end
            ST_DIFF: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_load) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DIFF;
                        n_axis  = r_axis + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_tmo <= w_tmo;
            r_s   <= S_ONE;
        end
        if ((r_state == ST_DIV) && w_div.done) begin
            r_s <= SB'(w_div.quo);
        end
        if (r_state == ST_CUBE) begin
            r_s2 <= w_prod[SQW-1:0];
        end
        if (r_state == ST_BLEND) begin
            r_h <= w_hfull[2*SF+HB-1:2*SF];
        end
        // magnitude and sign of end - start, both subtracts in parallel
        if (r_state == ST_DIFF) begin
            r_st  <= w_rstart;
            r_neg <= (w_rend < w_rstart);
            r_mag <= (w_rend < w_rstart)
                   ? ((PB+1)'(w_rstart) - (PB+1)'(w_rend))
                   : ((PB+1)'(w_rend) - (PB+1)'(w_rstart));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.out_axis  <= AX_ID'(r_axis);
            r_out.position  <= w_pos;
            r_out.timed_out <= r_tmo;
            r_out.last      <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // h never exceeds one, and a timed-out evaluate uses exactly one
    a_h_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF) |-> (r_h <= H_ONE))
        else $error("blend factor above one");

    a_tmo_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIFF) && r_tmo) |-> (r_h == H_ONE))
        else $error("timed-out move not at end position");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (int'(r_axis) < AXES))
        else $error("axis counter out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_last) |=> (r_state == ST_IDLE) && o_out_valid && o_out.last)
        else $error("sequence did not end on final axis");

    a_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == ST_DIV))
        else $error("divider finished outside divide state");

endmodule

FILE: tb/tb_cubic_axis_trajectory_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cubic_axis_trajectory_core: self-checking bench of the trajectory core
// Drives load, begin, evaluate and unused-function items over a valid/ready
// channel, predicts each axis position with its own model of the cubic
// blend, and compares every result item field by field under varied
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_cubic_axis_trajectory_core;

    localparam int NUM_AXES   = cat_pkg::AXES_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int END_CYCLES  = 120;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    cat_pkg::t_in_item   in_item;
    logic                out_valid;
    logic                out_ready;
    cat_pkg::t_out_item  out_item;

    // trajectory state as the block should hold it
    logic signed [cat_pkg::POS_BITS-1:0]  axis_from [NUM_AXES];
    logic signed [cat_pkg::POS_BITS-1:0]  axis_to   [NUM_AXES];
    logic [cat_pkg::TICK_BITS-1:0]        move_t0;
    logic [cat_pkg::PERIOD_BITS-1:0]      move_len;

    cat_pkg::t_out_item  expected_positions [$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;
    int                  stall_cycles;

    cubic_axis_trajectory_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // model update for load and begin items; cubic blend of every axis at one tick, queued in axis order
    function automatic void predict_trajectory(cat_pkg::t_in_item item);
        logic [cat_pkg::TICK_BITS-1:0] elapsed;
        bit                            timeout;
        longint unsigned               s, h, mag, prod, q;
        longint                        st, en, diff, pos;
        cat_pkg::t_out_item            r;
        case (item.func)
            cat_pkg::FUNC_LOAD: begin
                if (item.axis_index < NUM_AXES) begin
                    axis_from[item.axis_index] = item.start_position;
                    axis_to[item.axis_index]   = item.end_position;
                end
            end
            cat_pkg::FUNC_BEGIN: begin
                move_t0  = item.tick_now;
                move_len = item.move_period_ms;
            end
            cat_pkg::FUNC_EVAL: begin
                elapsed = item.tick_now - move_t0;
                timeout = (move_len == 0) || (elapsed >= move_len);
                if (timeout) begin
                    s = 64'd65536;
                end else begin
                    s = (longint'(elapsed) << 16) / longint'(move_len);
                    if (s > 64'd65536)
                        s = 64'd65536;
                end
                h = (((3 * s * s) << 16) - 2 * s * s * s) >> 32;
                for (int i = 0; i < NUM_AXES; i++) begin
                    st   = longint'(axis_from[i]);
                    en   = longint'(axis_to[i]);
                    diff = en - st;
                    // offset rounds toward minus infinity
                    if (diff >= 0) begin
                        mag  = longint'(diff);
                        prod = mag * h;
                        q    = prod >> 16;
                        pos  = st + longint'(q);
                    end else begin
                        mag  = longint'(-diff);
                        prod = mag * h;
                        q    = (prod >> 16) + ((prod[15:0] != 16'd0) ? 1 : 0);
                        pos  = st - longint'(q);
                    end
                    if (pos > 64'sd2147483647)
                        pos = 64'sd2147483647;
                    else if (pos < -64'sd2147483648)
                        pos = -64'sd2147483648;
                    r.out_axis  = i[cat_pkg::AXIS_ID_BITS-1:0];
                    r.position  = pos[cat_pkg::POS_BITS-1:0];
                    r.timed_out = timeout;
                    r.last      = (i == NUM_AXES - 1);
                    expected_positions.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // item with every field random, callers override what matters
    function automatic cat_pkg::t_in_item rand_item();
        cat_pkg::t_in_item item;
        item.func           = 2'($urandom_range(3));
        item.axis_index     = 3'($urandom_range(7));
        item.start_position = $urandom;
        item.end_position   = $urandom;
        item.move_period_ms = 16'($urandom);
        item.tick_now       = $urandom;
        return item;
    endfunction

    function automatic cat_pkg::t_in_item load_item(int axis, logic [31:0] st,
                                                    logic [31:0] en);
        cat_pkg::t_in_item item;
        item                = rand_item();
        item.func           = cat_pkg::FUNC_LOAD;
        item.axis_index     = axis[cat_pkg::AXIS_ID_BITS-1:0];
        item.start_position = st;
        item.end_position   = en;
        return item;
    endfunction

    function automatic cat_pkg::t_in_item begin_item(logic [15:0] period,
                                                     logic [31:0] tick);
        cat_pkg::t_in_item item;
        item                = rand_item();
        item.func           = cat_pkg::FUNC_BEGIN;
        item.move_period_ms = period;
        item.tick_now       = tick;
        return item;
    endfunction

    function automatic cat_pkg::t_in_item eval_item(logic [31:0] tick);
        cat_pkg::t_in_item item;
        item          = rand_item();
        item.func     = cat_pkg::FUNC_EVAL;
        item.tick_now = tick;
        return item;
    endfunction

    // full-range or small position, so the blend sees both
    function automatic logic [31:0] pick_position();
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(1))
            return b;
        return {{12{b[19]}}, b[19:0]};
    endfunction

    // offer one item, hold it until accepted, then predict
    task automatic send_item(input cat_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        predict_trajectory(item);
    endtask

    // sender goes quiet until every expected result is back
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge i_clk);
    endtask

    // reset state, ignored items, endpoint extremes, period corners
    task automatic test_directed();
        logic [31:0] t0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        t0             = 32'hFFFF_FF00;
        // zero period after reset reads as timed out at the end values
        send_item(eval_item(32'h1234_5678));
        begin : noise_items
            cat_pkg::t_in_item item;
            item      = rand_item();
            item.func = FUNC_NONE;
            send_item(item);
        end
        // loads to axes past the last one change nothing
        send_item(load_item(6, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(load_item(7, 32'h1234_5678, 32'hDEAD_BEEF));
        send_item(eval_item(32'h0000_0000));
        send_item(load_item(0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(load_item(1, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(load_item(2, 32'h0001_0000, 32'h0001_0000));
        send_item(load_item(3, 32'h0000_0000, 32'h0000_0001));
        send_item(load_item(4, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(load_item(5, 32'h7FFF_0000, 32'hFFFF_FFFB));
        // longest period, start tick just before the counter wraps
        send_item(begin_item(16'hFFFF, t0));
        send_item(eval_item(t0));
        send_item(eval_item(t0 + 32'd32767));
        send_item(eval_item(t0 + 32'd65534));
        send_item(eval_item(t0 + 32'd65535));
        send_item(eval_item(t0 - 32'd1));
        // shortest period
        send_item(begin_item(16'd1, 32'd100));
        send_item(eval_item(32'd100));
        send_item(eval_item(32'd101));
        // zero period by a begin item, then a short period of three
        send_item(begin_item(16'd0, 32'd5));
        send_item(eval_item(32'd5));
        send_item(begin_item(16'd3, 32'd0));
        send_item(eval_item(32'd1));
        send_item(eval_item(32'd2));
        drain();
    endtask

    // mostly coherent moves with random content, some noise
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        cat_pkg::t_in_item item;
        int                sent;
        int                pick;
        int unsigned       span;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent           = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            item = rand_item();
            if (pick < 25) begin
                item = load_item(($urandom_range(19) == 0) ? $urandom_range(6, 7) :
                                 $urandom_range(0, NUM_AXES - 1),
                                 pick_position(), pick_position());
                sent += (item.axis_index < NUM_AXES);
            end else if (pick < 40) begin
                case ($urandom_range(9))
                    0:       item.move_period_ms = 16'd0;
                    1, 2, 3: item.move_period_ms = 16'($urandom_range(1, 64));
                    default: item.move_period_ms = 16'($urandom_range(1, 65535));
                endcase
                item.func = cat_pkg::FUNC_BEGIN;
                sent++;
            end else if (pick < 92) begin
                span = {16'd0, move_len};
                case ($urandom_range(9))
                    0, 1:    item.tick_now = $urandom;
                    2, 3:    item.tick_now = move_t0 + $urandom_range(0, 2 * span + 2);
                    default: item.tick_now = move_t0 + $urandom_range(0, span);
                endcase
                item.func = cat_pkg::FUNC_EVAL;
                sent++;
            end else begin
                item.func = FUNC_NONE;
            end
            send_item(item);
        end
        drain();
    endtask

    // receiver holds off while evaluates pile up, then the sender waits it out
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(begin_item(16'($urandom_range(100, 2000)), $urandom));
        hold_left = LONG_HOLD;
        for (int i = 0; i < 10; i++)
            send_item(eval_item(move_t0 + $urandom_range(0, 2100)));
        drain();
    endtask

    // receiver ready, with random stalls and the long hold-off
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        cat_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_positions.size() == 0) begin
                $error("unexpected result item: axis %0d position %h",
                       out_item.out_axis, out_item.position);
                mismatch_count++;
            end else begin
                want = expected_positions.pop_front();
                if (out_item.out_axis !== want.out_axis) begin
                    $error("out_axis: expected %0d, got %0d",
                           want.out_axis, out_item.out_axis);
                    mismatch_count++;
                end
                if (out_item.position !== want.position) begin
                    $error("position: expected %h, got %h",
                           want.position, out_item.position);
                    mismatch_count++;
                end
                if (out_item.timed_out !== want.timed_out) begin
                    $error("timed_out: expected %0d, got %0d",
                           want.timed_out, out_item.timed_out);
                    mismatch_count++;
                end
                if (out_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("cubic_axis_trajectory_core: mismatch");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        stall_cycles   = 0;
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_from[i] = '0;
            axis_to[i]   = '0;
        end
        move_t0  = '0;
        move_len = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 50, 0);
        test_random_traffic(60, 0, 50);
        test_random_traffic(60, 14, 14);
        test_backpressure();

        drain();
        repeat (END_CYCLES) @(posedge i_clk);
        if (expected_positions.size() != 0) begin
            $error("%0d expected result items never arrived", expected_positions.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("cubic_axis_trajectory_core: match");
        else
            $display("cubic_axis_trajectory_core: mismatch");
        $finish;
    end

endmodule
